// ===== hdl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the source text tokenizer
// Scan modes, token kind codes, error codes and the result record.
// ----------------------------------------------------------------------------
package stt_pkg;

	typedef enum logic [3:0] {
		M_IDLE  = 4'd0,
		M_IDENT = 4'd1,
		M_INT   = 4'd2,
		M_DOT   = 4'd3,
		M_FRAC  = 4'd4,
		M_STR   = 4'd5,
		M_ESC   = 4'd6,
		M_OP    = 4'd7,
		M_LINEC = 4'd8,
		M_BLOCK = 4'd9,
		M_BSTAR = 4'd10
	} mode_t;

	localparam logic [5:0] K_IDENT   = 6'd12;
	localparam logic [5:0] K_NUMBER  = 6'd13;
	localparam logic [5:0] K_STRING  = 6'd14;
	localparam logic [5:0] K_ASSIGN  = 6'd15;
	localparam logic [5:0] K_EQ      = 6'd16;
	localparam logic [5:0] K_NE      = 6'd17;
	localparam logic [5:0] K_NOT     = 6'd18;
	localparam logic [5:0] K_LT      = 6'd19;
	localparam logic [5:0] K_LE      = 6'd20;
	localparam logic [5:0] K_GT      = 6'd21;
	localparam logic [5:0] K_GE      = 6'd22;
	localparam logic [5:0] K_ANDAND  = 6'd23;
	localparam logic [5:0] K_OROR    = 6'd24;
	localparam logic [5:0] K_PLUS    = 6'd25;
	localparam logic [5:0] K_MINUS   = 6'd26;
	localparam logic [5:0] K_STAR    = 6'd27;
	localparam logic [5:0] K_SLASH   = 6'd28;
	localparam logic [5:0] K_PERCENT = 6'd29;
	localparam logic [5:0] K_SEMI    = 6'd30;
	localparam logic [5:0] K_COMMA   = 6'd31;
	localparam logic [5:0] K_DOT     = 6'd32;
	localparam logic [5:0] K_LPAREN  = 6'd33;
	localparam logic [5:0] K_RPAREN  = 6'd34;
	localparam logic [5:0] K_LBRACE  = 6'd35;
	localparam logic [5:0] K_RBRACE  = 6'd36;
	localparam logic [5:0] K_LBRACK  = 6'd37;
	localparam logic [5:0] K_RBRACK  = 6'd38;
	localparam logic [5:0] K_END     = 6'd39;
	localparam logic [5:0] K_UNKNOWN = 6'd40;

	localparam logic [1:0] E_NONE    = 2'd0;
	localparam logic [1:0] E_STRING  = 2'd1;
	localparam logic [1:0] E_COMMENT = 2'd2;
	localparam logic [1:0] E_CHAR    = 2'd3;

	localparam int NUM_KW = 12;

	// result queue slots; a power of two so the pointers wrap on their own
	localparam int QUEUE_DEPTH = 8;

	typedef struct packed {
		logic [5:0]  kind;
		logic        sb_valid;
		logic [7:0]  sb;
		logic [15:0] line;
		logic [15:0] col;
		logic [31:0] off;
		logic [15:0] len;
		logic [1:0]  err;
		logic        last;
	} result_t;

	localparam int RES_W = $bits(result_t);

	// keyword text, byte 0 first, padded with zeros
	function automatic logic [7:0] kw_char(input int k, input int i);
		logic [63:0] s;
		begin
			unique case (k)
				0:  s = {"let", 40'd0};
				1:  s = {"var", 40'd0};
				2:  s = {"const", 24'd0};
				3:  s = "function";
				4:  s = {"if", 48'd0};
				5:  s = {"else", 32'd0};
				6:  s = {"while", 24'd0};
				7:  s = {"for", 40'd0};
				8:  s = {"return", 16'd0};
				9:  s = {"true", 32'd0};
				10: s = {"false", 24'd0};
				default: s = {"null", 32'd0};
			endcase
			kw_char = s[63 - 8*i -: 8];
		end
	endfunction

	function automatic logic [3:0] kw_len(input int k);
		unique case (k)
			0, 1, 7:      kw_len = 4'd3;
			2, 6, 10:     kw_len = 4'd5;
			3:            kw_len = 4'd8;
			4:            kw_len = 4'd2;
			8:            kw_len = 4'd6;
			default:      kw_len = 4'd4;
		endcase
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		is_digit = (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"))
			|| (c == "_") || (c == "$");
	endfunction

	function automatic logic [15:0] inc16(input logic [15:0] v);
		inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic [31:0] inc32(input logic [31:0] v);
		inc32 = (v == 32'hFFFFFFFF) ? v : v + 32'd1;
	endfunction

endpackage

// ===== hdl/stt_front.sv =====
// ----------------------------------------------------------------------------
// stt_front: scanner front end
// Accepts one byte a cycle, advances the scan state and position counters and
// hands up to three result records to the back end in one transaction.
// ----------------------------------------------------------------------------
module stt_front #(
	parameter int MAX_KEYWORD_LEN = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          in_byte,
	input  logic                in_end,
	output stt_pkg::result_t    res [3],
	output logic [1:0]          res_n
);
	import stt_pkg::*;

	localparam int LW = $clog2(MAX_KEYWORD_LEN);

	mode_t       mode_q;
	logic [7:0]  pend_q, quote_q;
	logic [15:0] line_q, col_q, tline_q, tcol_q, len_q;
	logic [31:0] off_q, toff_q;
	logic [7:0]  kwbuf_q [MAX_KEYWORD_LEN];
	logic        toolong_q;

	mode_t       mode_d;
	logic [7:0]  pend_d, quote_d;
	logic [15:0] line_d, col_d, tline_d, tcol_d, len_d;
	logic [31:0] off_d, toff_d;
	logic        toolong_d;
	logic        kw_we;
	logic [LW-1:0] kw_wa;
	logic [7:0]  kw_wd;
	logic [5:0]  ident_k;

	// keyword match against the stored identifier bytes
	always_comb begin
		logic hit;
		ident_k = K_IDENT;
		for (int k = NUM_KW - 1; k >= 0; k--) begin
			hit = !toolong_q && (len_q == 16'(kw_len(k)));
			for (int i = 0; i < 8; i++)
				if (i < int'(kw_len(k)) && kwbuf_q[i] != kw_char(k, i))
					hit = 1'b0;
			if (hit)
				ident_k = 6'(k);
		end
	end

	always_comb begin
		logic [7:0]  c;
		logic [1:0]  n;
		logic        restart;
		logic [5:0]  sk;
		logic [15:0] dcol;
		logic [31:0] doff;
		logic [5:0]  two;
		result_t     r;
		c = in_byte;
		n = 2'd0;
		restart = 1'b0;
		two = 6'd0;
		sk = K_UNKNOWN;
		for (int j = 0; j < 3; j++)
			res[j] = '0;
		mode_d = mode_q; pend_d = pend_q; quote_d = quote_q;
		line_d = line_q; col_d = col_q; off_d = off_q;
		tline_d = tline_q; tcol_d = tcol_q; toff_d = toff_q;
		len_d = len_q; toolong_d = toolong_q;
		kw_we = 1'b0; kw_wa = '0; kw_wd = c;
		dcol = (col_q == 16'hFFFF) ? col_q : ((col_q > 16'd1) ? col_q - 16'd1 : 16'd1);
		doff = (off_q == 32'hFFFFFFFF) ? off_q : ((off_q != 0) ? off_q - 32'd1 : 32'd0);

		r = '0;
		r.line = tline_q; r.col = tcol_q; r.off = toff_q;

		if (in_end) begin
			r.len = len_q;
			unique case (mode_q)
				M_IDENT: begin r.kind = ident_k; res[0] = r; n = 2'd1; end
				M_INT, M_FRAC: begin r.kind = K_NUMBER; res[0] = r; n = 2'd1; end
				M_DOT: begin
					r.kind = K_NUMBER; res[0] = r;
					r.kind = K_DOT; r.line = line_q; r.col = dcol; r.off = doff;
					r.len = 16'd1; res[1] = r; n = 2'd2;
				end
				M_STR, M_ESC: begin
					r.kind = K_UNKNOWN; r.err = E_STRING; res[0] = r; n = 2'd1;
				end
				M_BLOCK, M_BSTAR: begin
					r.kind = K_UNKNOWN; r.err = E_COMMENT; res[0] = r; n = 2'd1;
				end
				M_OP: begin
					r.len = 16'd1;
					priority case (pend_q)
						"=": r.kind = K_ASSIGN;
						"!": r.kind = K_NOT;
						"<": r.kind = K_LT;
						">": r.kind = K_GT;
						"/": r.kind = K_SLASH;
						default: begin r.kind = K_UNKNOWN; r.err = E_CHAR; end
					endcase
					res[0] = r; n = 2'd1;
				end
				default: ;
			endcase
			r = '0;
			r.kind = K_END; r.line = line_q; r.col = col_q; r.off = off_q;
			res[n] = r;
			n = n + 2'd1;
			mode_d = M_IDLE; pend_d = '0; quote_d = '0;
			line_d = 16'd1; col_d = 16'd1; off_d = '0;
			tline_d = 16'd1; tcol_d = 16'd1; toff_d = '0;
			len_d = '0; toolong_d = 1'b0;
		end else begin
			unique case (mode_q)
				M_IDLE: restart = 1'b1;
				M_IDENT: begin
					if (is_alpha(c) || is_digit(c)) begin
						if (len_q < 16'(MAX_KEYWORD_LEN)) begin
							kw_we = 1'b1; kw_wa = len_q[LW-1:0];
						end else
							toolong_d = 1'b1;
						len_d = inc16(len_q);
					end else begin
						r.kind = ident_k; r.len = len_q; res[0] = r; n = 2'd1;
						restart = 1'b1;
					end
				end
				M_INT: begin
					if (is_digit(c)) len_d = inc16(len_q);
					else if (c == ".") mode_d = M_DOT;
					else begin
						r.kind = K_NUMBER; r.len = len_q; res[0] = r; n = 2'd1;
						restart = 1'b1;
					end
				end
				M_DOT: begin
					if (is_digit(c)) begin
						len_d = inc16(inc16(len_q)); mode_d = M_FRAC;
					end else begin
						r.kind = K_NUMBER; r.len = len_q; res[0] = r;
						r.kind = K_DOT; r.line = line_q; r.col = dcol; r.off = doff;
						r.len = 16'd1; res[1] = r; n = 2'd2;
						restart = 1'b1;
					end
				end
				M_FRAC: begin
					if (is_digit(c)) len_d = inc16(len_q);
					else begin
						r.kind = K_NUMBER; r.len = len_q; res[0] = r; n = 2'd1;
						restart = 1'b1;
					end
				end
				M_STR: begin
					len_d = inc16(len_q);
					if (c == quote_q) begin
						r.kind = K_STRING; r.len = len_d; res[0] = r; n = 2'd1;
						mode_d = M_IDLE;
					end else if (c == "\\") mode_d = M_ESC;
					else begin
						r.kind = K_STRING; r.sb_valid = 1'b1; r.sb = c;
						res[0] = r; n = 2'd1;
					end
				end
				M_ESC: begin
					len_d = inc16(len_q);
					r.kind = K_STRING; r.sb_valid = 1'b1;
					r.sb = (c == "n") ? 8'd10 : (c == "t") ? 8'd9 : (c == "r") ? 8'd13 : c;
					res[0] = r; n = 2'd1;
					mode_d = M_STR;
				end
				M_OP: begin
					if (pend_q == "/" && c == "/") mode_d = M_LINEC;
					else if (pend_q == "/" && c == "*") begin
						len_d = 16'd2; mode_d = M_BLOCK;
					end else begin
						if (c == "=") begin
							priority case (pend_q)
								"=": two = K_EQ;
								"!": two = K_NE;
								"<": two = K_LE;
								">": two = K_GE;
								default: ;
							endcase
						end
						if (pend_q == "&" && c == "&") two = K_ANDAND;
						if (pend_q == "|" && c == "|") two = K_OROR;
						if (two != 6'd0) begin
							r.kind = two; r.len = 16'd2; res[0] = r; n = 2'd1;
							mode_d = M_IDLE;
						end else begin
							r.len = 16'd1;
							priority case (pend_q)
								"=": r.kind = K_ASSIGN;
								"!": r.kind = K_NOT;
								"<": r.kind = K_LT;
								">": r.kind = K_GT;
								"/": r.kind = K_SLASH;
								default: begin r.kind = K_UNKNOWN; r.err = E_CHAR; end
							endcase
							res[0] = r; n = 2'd1;
							restart = 1'b1;
						end
					end
				end
				M_LINEC: if (c == 8'd10) mode_d = M_IDLE;
				M_BLOCK: begin
					len_d = inc16(len_q);
					if (c == "*") mode_d = M_BSTAR;
				end
				M_BSTAR: begin
					len_d = inc16(len_q);
					if (c == "/") mode_d = M_IDLE;
					else if (c != "*") mode_d = M_BLOCK;
				end
				default: restart = 1'b1;
			endcase

			// scan the byte as the first of a new token
			if (restart) begin
				mode_d = M_IDLE;
				priority case (c)
					"+": sk = K_PLUS;    "-": sk = K_MINUS;  "*": sk = K_STAR;
					"%": sk = K_PERCENT; ";": sk = K_SEMI;   ",": sk = K_COMMA;
					".": sk = K_DOT;     "(": sk = K_LPAREN; ")": sk = K_RPAREN;
					"{": sk = K_LBRACE;  "}": sk = K_RBRACE; "[": sk = K_LBRACK;
					"]": sk = K_RBRACK;
					default: sk = K_UNKNOWN;
				endcase
				if (c == " " || c == 8'd9 || c == 8'd13 || c == 8'd10) begin
				end else if (is_digit(c) || is_alpha(c) || c == "\"" || c == "'"
					|| c == "=" || c == "!" || c == "<" || c == ">" || c == "&"
					|| c == "|" || c == "/") begin
					tline_d = line_q; tcol_d = col_q; toff_d = off_q; len_d = 16'd1;
					if (is_digit(c)) mode_d = M_INT;
					else if (is_alpha(c)) begin
						mode_d = M_IDENT; kw_we = 1'b1; kw_wa = '0; toolong_d = 1'b0;
					end else if (c == "\"" || c == "'") begin
						mode_d = M_STR; quote_d = c;
					end else begin
						mode_d = M_OP; pend_d = c;
					end
				end else begin
					r = '0;
					r.kind = sk; r.line = line_q; r.col = col_q; r.off = off_q;
					r.len = 16'd1; r.err = (sk == K_UNKNOWN) ? E_CHAR : E_NONE;
					res[n] = r;
					n = n + 2'd1;
				end
			end

			if (c == 8'd10) begin
				line_d = inc16(line_q); col_d = 16'd1;
			end else
				col_d = inc16(col_q);
			off_d = inc32(off_q);
		end
		if (n != 2'd0)
			res[n - 2'd1].last = 1'b1;
		res_n = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; pend_q <= '0; quote_q <= '0;
			line_q <= 16'd1; col_q <= 16'd1; off_q <= '0;
			tline_q <= 16'd1; tcol_q <= 16'd1; toff_q <= '0;
			len_q <= '0; toolong_q <= 1'b0;
		end else if (in_valid) begin
			mode_q <= mode_d; pend_q <= pend_d; quote_q <= quote_d;
			line_q <= line_d; col_q <= col_d; off_q <= off_d;
			tline_q <= tline_d; tcol_q <= tcol_d; toff_q <= toff_d;
			len_q <= len_d; toolong_q <= toolong_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && kw_we)
			kwbuf_q[kw_wa] <= kw_wd;
	end

endmodule

// ===== hdl/stt_back.sv =====
// ----------------------------------------------------------------------------
// stt_back: result queue
// Holds result records in order and drains them one per pop; reports full
// while fewer than three free slots remain.
// ----------------------------------------------------------------------------
module stt_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  stt_pkg::result_t    wr_res [3],
	input  logic [1:0]          wr_n,
	output logic                full,
	output logic                empty,
	input  logic                pop,
	output stt_pkg::result_t    head
);
	import stt_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);

	result_t       mem_q [DEPTH];
	logic [AW-1:0] rd_q, wr_q;
	logic [AW:0]   cnt_q;
	logic          do_pop;
	logic [1:0]    n_in;

	assign empty  = (cnt_q == '0);
	assign full   = (cnt_q > (AW+1)'(DEPTH - 3));
	assign do_pop = pop && !empty;
	assign n_in   = wr_en ? wr_n : 2'd0;
	assign head   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++)
			if (2'(j) < n_in)
				mem_q[wr_q + AW'(j)] <= wr_res[j];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0; wr_q <= '0; cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + AW'(n_in);
			rd_q  <= rd_q + AW'(do_pop);
			cnt_q <= cnt_q + (AW+1)'(n_in) - (AW+1)'(do_pop);
		end
	end

endmodule

// ===== hdl/source_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer: streaming lexical analyzer
// Turns source bytes into tokens with kind, start position and length.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive text_byte / end_of_text and raise push; a transaction
//   completes on a clock edge with push high and full low. One byte can be
//   taken every cycle; each byte passes through the scanner in that cycle.
//   Result channel: while empty is low the oldest result sits on the result
//   ports; raise pop to take it. Results leave one per cycle with pop high.
//   Order: a byte's results are queued in its transaction, behind older ones.
//   A byte can cause up to three results (held token, dot after a number, its
//   own token); last_of_run marks the final one.
//   Throughput: one byte per cycle while results are drained as fast as they
//   arrive; the sustained rate is set by the single pop per cycle of the
//   result queue, so bursts of several results slow the input.
//   Stalls: when pop is held low the queue fills and full rises once fewer
//   than three free slots remain; the scanner then holds its state.
//   Reset: arst_n clears scan state, counters (line and column to one) and
//   empties the queue. An end_of_text transaction also returns the scanner
//   to its reset state after emitting the end token.
// ----------------------------------------------------------------------------
module source_text_tokenizer #(
	parameter int MAX_KEYWORD_LEN = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	output logic        empty,
	input  logic        pop,
	output logic [5:0]  token_kind,
	output logic        string_byte_valid,
	output logic [7:0]  string_byte,
	output logic [15:0] start_line,
	output logic [15:0] start_column,
	output logic [31:0] start_offset,
	output logic [15:0] token_length,
	output logic [1:0]  error_code,
	output logic        last_of_run
);
	import stt_pkg::*;

	result_t    res [3];
	logic [1:0] res_n;
	logic       accept;
	result_t    head;

	// advance the scanner only on an accepted transaction
	assign accept = push && !full;

	stt_front #(.MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.in_byte  (text_byte),
		.in_end   (end_of_text),
		.res      (res),
		.res_n    (res_n)
	);

	stt_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept),
		.wr_res (res),
		.wr_n   (res_n),
		.full   (full),
		.empty  (empty),
		.pop    (pop),
		.head   (head)
	);

	assign token_kind        = head.kind;
	assign string_byte_valid = head.sb_valid;
	assign string_byte       = head.sb;
	assign start_line        = head.line;
	assign start_column      = head.col;
	assign start_offset      = head.off;
	assign token_length      = head.len;
	assign error_code        = head.err;
	assign last_of_run       = head.last;

endmodule
